>>> sv/core_allocation_and_mapping_top_defines.svh
// Assertion macros for the core allocation and mapping block.
// Included by the top level; no other dependencies.
`ifndef CORE_ALLOCATION_AND_MAPPING_TOP_DEFINES_SVH
`define CORE_ALLOCATION_AND_MAPPING_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAMA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CAMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/cama_pkg.sv
// Shared types and constants for the core allocation and mapping block.
// No dependencies.
package cama_pkg;

    localparam int CORE_TOTAL_DEF = 4;

    localparam int KIND_W   = 3;
    localparam int DEV_W    = 4;
    localparam int COUNT_W  = 4;
    localparam int INDEX_W  = 3;
    localparam int LIST_W   = 4;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 4;
    localparam int MAPPED_W = 2;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_V2P     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LIST    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_P2V     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    localparam logic [DEV_W-1:0] DEV_FREE = 4'd0;

    // Flags the compare unit reports for the core under scan.
    typedef struct packed {
        logic owned;     // core belongs to the requesting device
        logic free;      // core has no owner
        logic grant;     // free and still needed by an allocate
        logic virt_hit;  // owned and its virtual number equals core_index
        logic at_idx;    // physical position equals core_index
        logic list_hit;  // owned and its virtual number is set in virt_mask
    } step_t;

endpackage

>>> sv/cama_owner_tbl.sv
// Owner table: one device id per physical core, zero when free.
// Depends on cama_pkg.
module cama_owner_tbl #(
    parameter int CORE_TOTAL = cama_pkg::CORE_TOTAL_DEF,
    localparam int CIDX_W = (CORE_TOTAL > 1) ? $clog2(CORE_TOTAL) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [CIDX_W-1:0]             rd_addr,
    output logic [cama_pkg::DEV_W-1:0]    rd_data,
    input  logic                          we,
    input  logic [CIDX_W-1:0]             wr_addr,
    input  logic [cama_pkg::DEV_W-1:0]    wr_data
);

    logic [cama_pkg::DEV_W-1:0] owner_reg [CORE_TOTAL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CORE_TOTAL; i++)
            begin
                owner_reg[i] <= cama_pkg::DEV_FREE;
            end
        end
        else if (we)
        begin
            owner_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = owner_reg[rd_addr];

endmodule

>>> sv/cama_step.sv
// Compare unit shared by every scan step: classifies one table entry
// against the latched request. Depends on cama_pkg.
module cama_step #(
    parameter int CORE_TOTAL = cama_pkg::CORE_TOTAL_DEF,
    localparam int CIDX_W = (CORE_TOTAL > 1) ? $clog2(CORE_TOTAL) : 1,
    localparam int CNT_W  = $clog2(CORE_TOTAL + 1)
) (
    input  logic [cama_pkg::DEV_W-1:0]   owner,
    input  logic [cama_pkg::DEV_W-1:0]   dev,
    input  logic [cama_pkg::COUNT_W-1:0] count,
    input  logic [cama_pkg::INDEX_W-1:0] idx,
    input  logic [cama_pkg::LIST_W-1:0]  list,
    input  logic [CIDX_W-1:0]            scan_idx,
    input  logic [CNT_W-1:0]             nfree,
    input  logic [CNT_W-1:0]             seen,
    output cama_pkg::step_t              flags
);

    logic [3:0]                    seen4;
    logic [3:0]                    nfree4;
    logic [cama_pkg::INDEX_W-1:0]  pos;

    always_comb
    begin
        seen4  = 4'(seen);
        nfree4 = 4'(nfree);
        pos    = cama_pkg::INDEX_W'(scan_idx);

        flags.owned    = (owner == dev);
        flags.free     = (owner == cama_pkg::DEV_FREE);
        flags.grant    = flags.free && (nfree4 < count);
        flags.virt_hit = flags.owned && (seen4 == {1'b0, idx});
        flags.at_idx   = (pos == idx);
        // only virtual cores 0..3 can appear in the list
        flags.list_hit = flags.owned && (seen4 < 4'd4) && list[seen4[1:0]];
    end

endmodule

>>> sv/core_allocation_and_mapping_top.sv
// A request rejected on its fields skips the scan and goes straight to finish.
// One request at a time: busy stays high while the owner table is scanned one
// core per cycle through the shared compare unit, then, for a granted allocate,
// written back one core per cycle. Result shows for one cycle with done, cannot
// stall; next start is taken then.
// Reset clears the owner table (all cores free), the sequencer and done.
`include "core_allocation_and_mapping_top_defines.svh"

module core_allocation_and_mapping_top #(
    parameter int CORE_TOTAL = cama_pkg::CORE_TOTAL_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [cama_pkg::KIND_W-1:0]       kind,
    input  logic [cama_pkg::DEV_W-1:0]        device_id,
    input  logic [cama_pkg::COUNT_W-1:0]      core_count,
    input  logic [cama_pkg::INDEX_W-1:0]      core_index,
    input  logic [cama_pkg::LIST_W-1:0]       virt_mask,
    output logic                              done,
    output logic [cama_pkg::STATUS_W-1:0]     status,
    output logic [cama_pkg::MASK_W-1:0]       core_mask,
    output logic [cama_pkg::MAPPED_W-1:0]     mapped_index
);

    localparam int CIDX_W = (CORE_TOTAL > 1) ? $clog2(CORE_TOTAL) : 1;
    localparam int CNT_W  = $clog2(CORE_TOTAL + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic [cama_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [cama_pkg::DEV_W-1:0]      dev_reg, dev_next;
    logic [cama_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [cama_pkg::INDEX_W-1:0]    idx_reg, idx_next;
    logic [cama_pkg::LIST_W-1:0]     list_reg, list_next;
    logic                            bad_reg, bad_next;
    logic [CIDX_W-1:0]               scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]                nfree_reg, nfree_next;
    logic [CNT_W-1:0]                seen_reg, seen_next;
    logic [CORE_TOTAL-1:0]           grant_reg, grant_next;
    logic [CORE_TOTAL-1:0]           pm_reg, pm_next;
    logic                            found_reg, found_next;
    logic [cama_pkg::MAPPED_W-1:0]   mapped_reg, mapped_next;
    logic                            done_reg, done_next;
    logic [cama_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [cama_pkg::MASK_W-1:0]     core_mask_reg, core_mask_next;
    logic [cama_pkg::MAPPED_W-1:0]   mapped_index_reg, mapped_index_next;

    logic [cama_pkg::DEV_W-1:0]      owner_rd;
    logic                            tbl_we;
    logic [cama_pkg::DEV_W-1:0]      tbl_wdata;
    cama_pkg::step_t                 step;
    logic                            req_ok;
    logic                            scan_last;
    logic [3:0]                      vmask;
    logic                            list_bad;

    cama_owner_tbl #(
        .CORE_TOTAL (CORE_TOTAL)
    ) u_owner_tbl (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (scan_idx_reg),
        .rd_data (owner_rd),
        .we      (tbl_we),
        .wr_addr (scan_idx_reg),
        .wr_data (tbl_wdata)
    );

    cama_step #(
        .CORE_TOTAL (CORE_TOTAL)
    ) u_step (
        .owner    (owner_rd),
        .dev      (dev_reg),
        .count    (count_reg),
        .idx      (idx_reg),
        .list     (list_reg),
        .scan_idx (scan_idx_reg),
        .nfree    (nfree_reg),
        .seen     (seen_reg),
        .flags    (step)
    );

    assign busy      = (state_reg != S_IDLE);
    assign scan_last = (scan_idx_reg == CIDX_W'(CORE_TOTAL - 1));

    always_comb
    begin
        req_ok = (device_id != cama_pkg::DEV_FREE) && (kind <= cama_pkg::KIND_P2V) &&
                 !((kind == cama_pkg::KIND_ALLOC) &&
                   ((core_count == '0) || (core_count > 4'(CORE_TOTAL))));

        // virtual cores that exist for this device
        for (int v = 0; v < 4; v++)
        begin
            vmask[v] = (4'(seen_reg) > 4'(v));
        end
        list_bad = |(list_reg & ~vmask);
    end

    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        dev_next          = dev_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        list_next         = list_reg;
        bad_next          = bad_reg;
        scan_idx_next     = scan_idx_reg;
        nfree_next        = nfree_reg;
        seen_next         = seen_reg;
        grant_next        = grant_reg;
        pm_next           = pm_reg;
        found_next        = found_reg;
        mapped_next       = mapped_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        core_mask_next    = core_mask_reg;
        mapped_index_next = mapped_index_reg;
        tbl_we            = 1'b0;
        tbl_wdata         = cama_pkg::DEV_FREE;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next     = kind;
                    dev_next      = device_id;
                    count_next    = core_count;
                    idx_next      = core_index;
                    list_next     = virt_mask;
                    bad_next      = !req_ok;
                    scan_idx_next = '0;
                    nfree_next    = '0;
                    seen_next     = '0;
                    grant_next    = '0;
                    pm_next       = '0;
                    found_next    = 1'b0;
                    mapped_next   = '0;
                    state_next    = req_ok ? S_SCAN : S_FINISH;
                end
            end

            S_SCAN:
            begin
                nfree_next = nfree_reg + CNT_W'(step.free);
                seen_next  = seen_reg + CNT_W'(step.owned);
                if (step.list_hit)
                begin
                    pm_next[scan_idx_reg] = 1'b1;
                end
                case (kind_reg)
                    cama_pkg::KIND_ALLOC:
                    begin
                        if (step.grant)
                        begin
                            grant_next[scan_idx_reg] = 1'b1;
                        end
                    end
                    cama_pkg::KIND_RELEASE:
                    begin
                        // free the core as it is found
                        if (step.owned)
                        begin
                            grant_next[scan_idx_reg] = 1'b1;
                            tbl_we                   = 1'b1;
                        end
                    end
                    cama_pkg::KIND_V2P:
                    begin
                        if (step.virt_hit)
                        begin
                            found_next  = 1'b1;
                            mapped_next = cama_pkg::MAPPED_W'(scan_idx_reg);
                        end
                    end
                    cama_pkg::KIND_P2V:
                    begin
                        // owned cores seen so far are exactly those below core_index
                        if (step.at_idx && step.owned)
                        begin
                            found_next  = 1'b1;
                            mapped_next = cama_pkg::MAPPED_W'(seen_reg);
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (scan_last)
                begin
                    scan_idx_next = '0;
                    if ((kind_reg == cama_pkg::KIND_ALLOC) && (4'(nfree_next) >= count_reg))
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CIDX_W'(1);
                end
            end

            S_WRITE:
            begin
                tbl_we    = grant_reg[scan_idx_reg];
                tbl_wdata = dev_reg;
                if (scan_last)
                begin
                    scan_idx_next = '0;
                    state_next    = S_FINISH;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CIDX_W'(1);
                end
            end

            S_FINISH:
            begin
                done_next         = 1'b1;
                status_next       = cama_pkg::ST_INVALID;
                core_mask_next    = '0;
                mapped_index_next = '0;
                state_next        = S_IDLE;
                if (!bad_reg)
                begin
                    case (kind_reg)
                        cama_pkg::KIND_ALLOC:
                        begin
                            if (4'(nfree_reg) < count_reg)
                            begin
                                status_next = cama_pkg::ST_BUSY;
                            end
                            else
                            begin
                                status_next    = cama_pkg::ST_OK;
                                core_mask_next = cama_pkg::MASK_W'(grant_reg);
                            end
                        end
                        cama_pkg::KIND_RELEASE:
                        begin
                            status_next    = cama_pkg::ST_OK;
                            core_mask_next = cama_pkg::MASK_W'(grant_reg);
                        end
                        cama_pkg::KIND_LIST:
                        begin
                            if (!list_bad)
                            begin
                                status_next    = cama_pkg::ST_OK;
                                core_mask_next = cama_pkg::MASK_W'(pm_reg);
                            end
                        end
                        cama_pkg::KIND_V2P,
                        cama_pkg::KIND_P2V:
                        begin
                            if (found_reg)
                            begin
                                status_next       = cama_pkg::ST_OK;
                                mapped_index_next = mapped_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            kind_reg         <= '0;
            dev_reg          <= '0;
            count_reg        <= '0;
            idx_reg          <= '0;
            list_reg         <= '0;
            bad_reg          <= 1'b0;
            scan_idx_reg     <= '0;
            nfree_reg        <= '0;
            seen_reg         <= '0;
            grant_reg        <= '0;
            pm_reg           <= '0;
            found_reg        <= 1'b0;
            mapped_reg       <= '0;
            done_reg         <= 1'b0;
            status_reg       <= '0;
            core_mask_reg    <= '0;
            mapped_index_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            kind_reg         <= kind_next;
            dev_reg          <= dev_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            list_reg         <= list_next;
            bad_reg          <= bad_next;
            scan_idx_reg     <= scan_idx_next;
            nfree_reg        <= nfree_next;
            seen_reg         <= seen_next;
            grant_reg        <= grant_next;
            pm_reg           <= pm_next;
            found_reg        <= found_next;
            mapped_reg       <= mapped_next;
            done_reg         <= done_next;
            status_reg       <= status_next;
            core_mask_reg    <= core_mask_next;
            mapped_index_reg <= mapped_index_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign core_mask    = core_mask_reg;
    assign mapped_index = mapped_index_reg;

    `CAMA_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `CAMA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `CAMA_ASSERT_IMP(a_fail_clean, clk, rst_n, done && (status != cama_pkg::ST_OK), (core_mask == '0) && (mapped_index == '0))
    `CAMA_ASSERT_IMP(a_write_busy, clk, rst_n, tbl_we, busy && !done)

endmodule
